@@ rtl/cascaded_biquad_audio_filter_defines.svh @@
// ---------------------------------------------------------------------------
// Cascaded biquad audio filter assertion macros
// Shared property macros for the checker, clocked on clock, off in reset.
// ---------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_AUDIO_FILTER_DEFINES_SVH
`define CASCADED_BIQUAD_AUDIO_FILTER_DEFINES_SVH

// same-cycle implication
`define CBAF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBAF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cbaf_pkg.sv @@
// ---------------------------------------------------------------------------
// Cascaded biquad audio filter package
// Widths, register indexes and shared types of the filter and its sections.
// ---------------------------------------------------------------------------
`default_nettype none

package cbaf_pkg;

   // sample and coefficient formats
   localparam int SAMPLE_W      = 16;
   localparam int COEF_W        = 20;
   localparam int COEF_FRAC     = 17;
   localparam int HISTORY_WIDTH = 24;
   localparam int NUM_STAGES    = 3;
   localparam int MAX_STAGES    = 3;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 3 * COEF_W;

   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_EN  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_EN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STAGE_ONE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STAGE_TWO  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STAGE_THREE = 3'd4;

   // coefficient set of one section, a1 in the low bits
   typedef struct packed {
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] a1;
   } coef_type;

   // control handed to each section
   typedef struct packed {
      logic start;
      logic clear;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ rtl/cbaf_section.sv @@
// ---------------------------------------------------------------------------
// Biquad section cell
// One direct-form-I section: five products through one multiplier, then
// rounding and saturation; keeps its own input and output histories.
// ---------------------------------------------------------------------------
`default_nettype none

module cbaf_section #(
   parameter int HW       = cbaf_pkg::HISTORY_WIDTH,
   parameter bit LOW_PASS = 1'b0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cbaf_pkg::cell_ctl_type    ctl,
   input  cbaf_pkg::coef_type        coef,
   input  logic signed [HW-1:0]      x_in,
   output logic                      done,
   output logic signed [HW-1:0]      y_out
);

   localparam int CW = cbaf_pkg::COEF_W;
   localparam int PW = CW + HW;
   localparam int AW = PW + 4;

   localparam logic [2:0] STEP_X0    = 3'd0;
   localparam logic [2:0] STEP_X1    = 3'd1;
   localparam logic [2:0] STEP_X2    = 3'd2;
   localparam logic [2:0] STEP_Y1    = 3'd3;
   localparam logic [2:0] STEP_Y2    = 3'd4;
   localparam logic [2:0] STEP_LAST  = 3'd5;
   localparam logic [2:0] STEP_ROUND = 3'd6;

   localparam logic signed [AW-1:0] HALF_LSB = AW'(1) <<< (cbaf_pkg::COEF_FRAC - 1);

   logic                 busy_ff;
   logic [2:0]           step_ff;
   logic                 done_ff;
   logic signed [HW-1:0] x0_ff, x1_ff, x2_ff, y1_ff, y2_ff, y_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;

   logic signed [CW-1:0] mul_c;
   logic signed [HW-1:0] mul_d;
   logic signed [PW-1:0] prod_in;
   logic signed [AW-1:0] prod_ext;
   logic signed [AW-1:0] term;
   logic signed [AW-1:0] acc_in;
   logic signed [AW-1:0] rnd;
   logic signed [AW-1:0] shifted;
   logic signed [HW-1:0] ysat;
   logic [AW-HW:0]       upper;

   // operand select for the shared multiplier
   always_comb begin
      unique case (step_ff)
         STEP_X0: begin
            mul_c = coef.a1;
            mul_d = x0_ff;
         end
         STEP_X1: begin
            mul_c = coef.a1;
            mul_d = x1_ff;
         end
         STEP_X2: begin
            mul_c = coef.a1;
            mul_d = x2_ff;
         end
         STEP_Y1: begin
            mul_c = coef.b1;
            mul_d = y1_ff;
         end
         STEP_Y2: begin
            mul_c = coef.b2;
            mul_d = y2_ff;
         end
         default: begin
            mul_c = coef.a1;
            mul_d = x0_ff;
         end
      endcase
   end

   assign prod_in  = PW'(mul_c) * PW'(mul_d);
   assign prod_ext = {{(AW-PW){prod_ff[PW-1]}}, prod_ff};

   // accumulate the product of the previous step
   always_comb begin
      unique case (step_ff)
         STEP_X1:   term = prod_ext;
         STEP_X2:   term = LOW_PASS ? (prod_ext <<< 1) : -(prod_ext <<< 1);
         STEP_Y1:   term = prod_ext;
         STEP_Y2:   term = -prod_ext;
         STEP_LAST: term = -prod_ext;
         default:   term = '0;
      endcase
   end

   assign acc_in = acc_ff + term;

   // round half up, drop fraction bits, saturate to history width
   assign rnd     = acc_ff + HALF_LSB;
   assign shifted = rnd >>> cbaf_pkg::COEF_FRAC;
   assign upper   = shifted[AW-1:HW-1];

   always_comb begin
      if ((&upper) || !(|upper)) begin
         ysat = shifted[HW-1:0];
      end else if (upper[AW-HW]) begin
         ysat = {1'b1, {(HW-1){1'b0}}};
      end else begin
         ysat = {1'b0, {(HW-1){1'b1}}};
      end
   end

   // control and histories
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_X0;
         done_ff <= 1'b0;
         x1_ff   <= '0;
         x2_ff   <= '0;
         y1_ff   <= '0;
         y2_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.clear) begin
            x1_ff <= '0;
            x2_ff <= '0;
            y1_ff <= '0;
            y2_ff <= '0;
         end
         if (ctl.start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_X0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == STEP_ROUND) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               x2_ff   <= x1_ff;
               x1_ff   <= x0_ff;
               y2_ff   <= y1_ff;
               y1_ff   <= ysat;
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         x0_ff  <= x_in;
         acc_ff <= '0;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
         if (step_ff == STEP_ROUND) begin
            y_ff <= ysat;
         end
      end
   end

   assign done  = done_ff;
   assign y_out = y_ff;

endmodule

`default_nettype wire

@@ rtl/cascaded_biquad_audio_filter.sv @@
// ---------------------------------------------------------------------------
// Cascaded biquad audio filter
// Up to three biquad sections in a row (high-pass, high-pass, low-pass)
// on a stream of Q1.15 samples, with saturation to 16 bits.
//
// req_ carries one sample per request; rsp_ carries one result per request
// while output is enabled, none while it is disabled. csr_ writes a register
// by index (output enable, filter enable, one coefficient set per section);
// write only while idle.
// Each section is a cell with one multiplier doing five products in turn.
// The block takes no new request until the last result has moved on from
// the result register to the output register. A passed sample skips the
// sections and goes straight to the result register; a swallowed request
// leaves the block idle and ready for the next one.
// If the receiver stalls, the result waits in the output register and the
// next one waits inside the block, with req_tready low.
// Reset empties the output, enables output, disables filtering and zeroes
// coefficients and histories. Turning filtering on clears the histories.
// ---------------------------------------------------------------------------
`default_nettype none

module cascaded_biquad_audio_filter #(
   parameter int NUM_STAGES    = cbaf_pkg::NUM_STAGES,
   parameter int HISTORY_WIDTH = cbaf_pkg::HISTORY_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [cbaf_pkg::SAMPLE_W-1:0]        req_tdata,   // [15:0] audio_in
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [cbaf_pkg::SAMPLE_W-1:0]        rsp_tdata,   // [15:0] audio_out
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cbaf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbaf_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int HW = HISTORY_WIDTH;
   localparam int SW = cbaf_pkg::SAMPLE_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic                             output_en_ff;
   logic                             filter_en_ff;
   logic [cbaf_pkg::CSR_DATA_W-1:0]  coef_ff [cbaf_pkg::MAX_STAGES];
   logic [SW-1:0]                    result_ff, result_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                    rsp_data_ff;

   logic                             req_accept;
   logic                             csr_accept;
   logic                             clear_hist;
   logic                             chain_start;
   logic                             load_out;
   logic signed [HW-1:0]             x_first;
   logic                             cell_done [NUM_STAGES];
   logic signed [HW-1:0]             cell_y [NUM_STAGES];
   logic signed [HW-1:0]             chain_y;
   logic                             chain_done;
   logic [HW-SW:0]                   y_upper;
   logic [SW-1:0]                    y_sat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   // histories clear when filtering turns on
   assign clear_hist = csr_accept && (csr_index == cbaf_pkg::REG_FILTER_EN) &&
                       csr_data[0] && !filter_en_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         output_en_ff <= 1'b1;
         filter_en_ff <= 1'b0;
         for (int i = 0; i < cbaf_pkg::MAX_STAGES; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_accept) begin
         unique case (csr_index)
            cbaf_pkg::REG_OUTPUT_EN:   output_en_ff <= csr_data[0];
            cbaf_pkg::REG_FILTER_EN:   filter_en_ff <= csr_data[0];
            cbaf_pkg::REG_STAGE_ONE:   coef_ff[0]   <= csr_data;
            cbaf_pkg::REG_STAGE_TWO:   coef_ff[1]   <= csr_data;
            cbaf_pkg::REG_STAGE_THREE: coef_ff[2]   <= csr_data;
            default: ;
         endcase
      end
   end

   // section chain
   assign chain_start = req_accept && output_en_ff && filter_en_ff;
   assign x_first     = {{(HW-SW){req_tdata[SW-1]}}, req_tdata};

   for (genvar gi = 0; gi < NUM_STAGES; gi++) begin : g_cell
      cbaf_pkg::cell_ctl_type ctl;
      logic                   cell_start;
      logic signed [HW-1:0]   x_in;

      if (gi == 0) begin : g_head
         assign cell_start = chain_start;
         assign x_in       = x_first;
      end else begin : g_link
         assign cell_start = cell_done[gi-1];
         assign x_in       = cell_y[gi-1];
      end
      assign ctl = '{start: cell_start, clear: clear_hist};

      cbaf_section #(
         .HW       (HW),
         .LOW_PASS (gi == 2)
      ) u_section (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .coef  (cbaf_pkg::coef_type'(coef_ff[gi])),
         .x_in  (x_in),
         .done  (cell_done[gi]),
         .y_out (cell_y[gi])
      );
   end

   assign chain_done = cell_done[NUM_STAGES-1];
   assign chain_y    = cell_y[NUM_STAGES-1];

   // saturate the last section output to 16 bits
   assign y_upper = chain_y[HW-1:SW-1];

   always_comb begin
      if ((&y_upper) || !(|y_upper)) begin
         y_sat = chain_y[SW-1:0];
      end else if (y_upper[HW-SW]) begin
         y_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SW-1){1'b1}}};
      end
   end

   // sequencer
   assign load_out = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && output_en_ff) begin
               if (filter_en_ff) begin
                  state_in = ST_BUSY;
               end else begin
                  result_in = req_tdata;
                  state_in  = ST_HOLD;
               end
            end
         end
         ST_BUSY: begin
            if (chain_done) begin
               result_in = y_sat;
               state_in  = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (load_out) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/cbaf_checker.sv @@
// ---------------------------------------------------------------------------
// Cascaded biquad audio filter port checker
// Watches the top-level ports for output ordering and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none

`include "cascaded_biquad_audio_filter_defines.svh"

module cbaf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [cbaf_pkg::SAMPLE_W-1:0]       req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [cbaf_pkg::SAMPLE_W-1:0]       rsp_tdata
);

   // a stalled result holds
   `CBAF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // a new result only appears after the block stopped taking requests
   `CBAF_ASSERT_NOW(a_rsp_after_work, $rose(rsp_tvalid), !$past(req_tready), "result without a request in work")

   // output register empty after reset
   `CBAF_ASSERT_NOW(a_reset_empty, $fell(reset), !rsp_tvalid, "result valid after reset")

   // a taken request carries known data
   `CBAF_ASSERT_NOW(a_req_data_known, req_tvalid && req_tready, !$isunknown(req_tdata), "request data unknown")

endmodule

bind cascaded_biquad_audio_filter cbaf_checker u_cbaf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
